>>> hdl/rcfd_pkg.sv
// Package for the remote-control frame decoder: sizes, register indexes and shared types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rcfd_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int STORED_BYTES = 16;
    localparam int COUNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int STORE_IDX_W = $clog2(STORED_BYTES);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_BAND     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH  = 2'd2;

    localparam logic [9:0]  DEAD_BAND_RESET     = 10'd6;
    localparam logic [10:0] CHANNEL_LIMIT_RESET = 11'd650;
    localparam logic [7:0]  FRAME_LENGTH_RESET  = 8'd18;

    typedef logic [STORED_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> hdl/rcfd_front.sv
// Front end of the frame decoder: counts and stores received bytes, and on a line-idle
// word with a matching count pushes a snapshot of the stored frame. Uses rcfd_pkg.
`default_nettype none

module rcfd_front
    import rcfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          line_idle,
    input  wire logic [7:0]    frame_length,
    input  wire queue_status_t q_status,
    output logic               push,
    output frame_t             push_frame
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    frame_t             frame_reg;
    frame_t             frame_next;
    logic               accept;
    logic               match;

    assign in_ready = !q_status.full;
    assign accept = in_valid && in_ready;
    assign match = ({{(COUNT_W + 8){1'b0}}, count_reg}
                    == {{COUNT_W{1'b0}}, 8'(0), frame_length} ) ? 1'b1 : 1'b0;
    assign push = accept && line_idle && match;
    assign push_frame = frame_reg;

    always_comb
    begin
        count_next = count_reg;
        frame_next = frame_reg;
        if (accept)
        begin
            if (line_idle)
            begin
                count_next = '0;
            end
            else if (count_reg < COUNT_W'(BUFFER_DEPTH))
            begin
                if (count_reg < COUNT_W'(STORED_BYTES))
                begin
                    frame_next[count_reg[STORE_IDX_W-1:0]] = rx_byte;
                end
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            frame_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rcfd_queue.sv
// Two-entry register queue of frame snapshots between front and back end.
// Uses rcfd_pkg for the frame type and the status struct.
`default_nettype none

module rcfd_queue
    import rcfd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire frame_t push_frame,
    input  wire logic   pop,
    output frame_t      pop_frame,
    output queue_status_t q_status
);

    frame_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] fill_reg;
    logic [QUEUE_CNT_W-1:0] fill_next;

    assign q_status.full = (fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign pop_frame = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rcfd_back.sv
// Back end of the frame decoder: unpacks a queued frame, shapes the stick channels,
// tracks the switches and holds the result word in an output register. Uses rcfd_pkg.
`default_nettype none

module rcfd_back
    import rcfd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t q_status,
    input  wire frame_t        pop_frame,
    output logic               pop,
    input  wire logic [9:0]    dead_band,
    input  wire logic [10:0]   channel_limit,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic signed [10:0] stick_one,
    output logic signed [10:0] stick_two,
    output logic signed [10:0] stick_three,
    output logic signed [10:0] stick_four,
    output logic [3:0]         switches_now,
    output logic [3:0]         switches_before,
    output logic signed [15:0] mouse_x,
    output logic signed [15:0] mouse_y,
    output logic signed [15:0] mouse_z,
    output logic [7:0]         left_button,
    output logic [7:0]         right_button,
    output logic [15:0]        key_bits
);

    logic              out_valid_reg;
    logic [1:0]        sw_one_reg;
    logic [1:0]        sw_two_reg;
    logic [1:0]        sw_one_before_reg;
    logic [1:0]        sw_two_before_reg;
    logic [1:0]        sw_one_next;
    logic [1:0]        sw_two_next;
    logic [1:0]        sw_one_before_next;
    logic [1:0]        sw_two_before_next;
    logic [10:0]       raw [4];
    logic signed [10:0] shaped [4];
    logic signed [10:0] stick_reg [4];
    logic [3:0]        sw_now_reg;
    logic [3:0]        sw_before_reg;
    logic [15:0]       mouse_x_reg;
    logic [15:0]       mouse_y_reg;
    logic [15:0]       mouse_z_reg;
    logic [7:0]        left_reg;
    logic [7:0]        right_reg;
    logic [15:0]       key_reg;

    function automatic logic signed [10:0] shape(input logic [10:0] r,
                                                 input logic [9:0] db,
                                                 input logic [10:0] lim);
        logic signed [12:0] v;
        logic signed [12:0] db_s;
        logic signed [12:0] lim_s;
        logic signed [12:0] res;
        v = 13'(signed'({~r[10], r[9:0]}));
        db_s = signed'({3'b000, db});
        lim_s = signed'({2'b00, lim});
        res = v;
        if (v <= db_s && v >= -db_s)
        begin
            res = '0;
        end
        if (res > lim_s)
        begin
            res = lim_s;
        end
        if (res < -lim_s)
        begin
            res = -lim_s;
        end
        return res[10:0];
    endfunction

    assign pop = !q_status.empty && (!out_valid_reg || out_ready);

    assign raw[0] = {pop_frame[1][2:0], pop_frame[0]};
    assign raw[1] = {pop_frame[2][5:0], pop_frame[1][7:3]};
    assign raw[2] = {pop_frame[4][0], pop_frame[3], pop_frame[2][7:6]};
    assign raw[3] = {pop_frame[5][3:0], pop_frame[4][7:1]};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            shaped[i] = shape(raw[i], dead_band, channel_limit);
        end
    end

    always_comb
    begin
        sw_one_next = pop_frame[5][7:6];
        sw_two_next = pop_frame[5][5:4];
        sw_one_before_next = sw_one_before_reg;
        sw_two_before_next = sw_two_before_reg;
        if (sw_one_next != sw_one_reg)
        begin
            sw_one_before_next = sw_one_reg;
        end
        if (sw_two_next != sw_two_reg)
        begin
            sw_two_before_next = sw_two_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sw_one_reg <= '0;
            sw_two_reg <= '0;
            sw_one_before_reg <= '0;
            sw_two_before_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                sw_one_reg <= sw_one_next;
                sw_two_reg <= sw_two_next;
                sw_one_before_reg <= sw_one_before_next;
                sw_two_before_reg <= sw_two_before_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 4; i++)
            begin
                stick_reg[i] <= shaped[i];
            end
            sw_now_reg <= {sw_one_next, sw_two_next};
            sw_before_reg <= {sw_one_before_next, sw_two_before_next};
            mouse_x_reg <= {pop_frame[7], pop_frame[6]};
            mouse_y_reg <= {pop_frame[9], pop_frame[8]};
            mouse_z_reg <= {pop_frame[11], pop_frame[10]};
            left_reg <= pop_frame[12];
            right_reg <= pop_frame[13];
            key_reg <= {pop_frame[15], pop_frame[14]};
        end
    end

    assign out_valid = out_valid_reg;
    assign stick_one = stick_reg[0];
    assign stick_two = stick_reg[1];
    assign stick_three = stick_reg[2];
    assign stick_four = stick_reg[3];
    assign switches_now = sw_now_reg;
    assign switches_before = sw_before_reg;
    assign mouse_x = signed'(mouse_x_reg);
    assign mouse_y = signed'(mouse_y_reg);
    assign mouse_z = signed'(mouse_z_reg);
    assign left_button = left_reg;
    assign right_button = right_reg;
    assign key_bits = key_reg;

endmodule

`default_nettype wire

>>> hdl/rc_receiver_frame_decoder.sv
// Top level of the remote-control frame decoder: configuration registers and the
// front end, frame queue and back end. Uses rcfd_pkg, rcfd_front, rcfd_queue, rcfd_back.
//
// The input channel takes one word per cycle: a received byte, or a line-idle word
// that ends a burst. A burst whose byte count (which saturates at BUFFER_DEPTH) equals
// frame_length produces one result word on the output channel; any other idle produces
// nothing. A decoding idle's frame is queued and then loaded into the output register;
// a new input word is taken every cycle while the two-entry frame queue has room.
// The configuration channel is always ready and writes dead_band, channel_limit and
// frame_length by index; other indexes are ignored.
// Reset clears the byte count, the stored frame bytes, the switch history and the
// queue, and loads the register defaults. When the receiver stalls, the result stays
// in the output register, the queue fills behind it, and in_ready drops only once
// the queue holds two frames; data bytes are then held off as well.
`default_nettype none

module rc_receiver_frame_decoder
    import rcfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   line_idle,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [10:0]          stick_one,
    output logic signed [10:0]          stick_two,
    output logic signed [10:0]          stick_three,
    output logic signed [10:0]          stick_four,
    output logic [3:0]                  switches_now,
    output logic [3:0]                  switches_before,
    output logic signed [15:0]          mouse_x,
    output logic signed [15:0]          mouse_y,
    output logic signed [15:0]          mouse_z,
    output logic [7:0]                  left_button,
    output logic [7:0]                  right_button,
    output logic [15:0]                 key_bits
);

    logic [9:0]    dead_band_reg;
    logic [10:0]   channel_limit_reg;
    logic [7:0]    frame_length_reg;
    queue_status_t q_status;
    logic          push;
    logic          pop;
    frame_t        push_frame;
    frame_t        pop_frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg <= DEAD_BAND_RESET;
            channel_limit_reg <= CHANNEL_LIMIT_RESET;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEAD_BAND:
                begin
                    dead_band_reg <= cfg_data[9:0];
                end
                CFG_CHANNEL_LIMIT:
                begin
                    channel_limit_reg <= cfg_data[10:0];
                end
                CFG_FRAME_LENGTH:
                begin
                    frame_length_reg <= cfg_data[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    rcfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .line_idle    (line_idle),
        .frame_length (frame_length_reg),
        .q_status     (q_status),
        .push         (push),
        .push_frame   (push_frame)
    );

    rcfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .q_status   (q_status)
    );

    rcfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .pop_frame       (pop_frame),
        .pop             (pop),
        .dead_band       (dead_band_reg),
        .channel_limit   (channel_limit_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stick_one       (stick_one),
        .stick_two       (stick_two),
        .stick_three     (stick_three),
        .stick_four      (stick_four),
        .switches_now    (switches_now),
        .switches_before (switches_before),
        .mouse_x         (mouse_x),
        .mouse_y         (mouse_y),
        .mouse_z         (mouse_z),
        .left_button     (left_button),
        .right_button    (right_button),
        .key_bits        (key_bits)
    );

endmodule

`default_nettype wire

>>> test/rcfd_checker.sv
// Checker for the remote-control frame decoder. It watches the input, configuration and
// result channels, predicts each decoded frame and compares it field by field.
// Depends on rcfd_pkg for sizes, register indexes and reset values.

module rcfd_checker
    import rcfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic                   line_idle,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic signed [10:0]     stick_one,
    input  logic signed [10:0]     stick_two,
    input  logic signed [10:0]     stick_three,
    input  logic signed [10:0]     stick_four,
    input  logic [3:0]             switches_now,
    input  logic [3:0]             switches_before,
    input  logic signed [15:0]     mouse_x,
    input  logic signed [15:0]     mouse_y,
    input  logic signed [15:0]     mouse_z,
    input  logic [7:0]             left_button,
    input  logic [7:0]             right_button,
    input  logic [15:0]            key_bits,
    output int                     outstanding,
    output int                     failures
);

    typedef struct packed {
        logic signed [10:0] stick_one;
        logic signed [10:0] stick_two;
        logic signed [10:0] stick_three;
        logic signed [10:0] stick_four;
        logic [3:0]         switches_now;
        logic [3:0]         switches_before;
        logic signed [15:0] mouse_x;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_z;
        logic [7:0]         left_button;
        logic [7:0]         right_button;
        logic [15:0]        key_bits;
    } rc_report_t;

    logic [9:0]  band;
    logic [10:0] clamp_lim;
    logic [7:0]  want_len;

    int          burst_len;
    logic [7:0]  held_bytes [STORED_BYTES];
    logic [1:0]  sw_one;
    logic [1:0]  sw_two;
    logic [1:0]  sw_one_prev;
    logic [1:0]  sw_two_prev;

    rc_report_t  pending_reports [$];
    int          miss_count = 0;

    initial outstanding = 0;
    initial failures = 0;

    function automatic logic signed [10:0] shape_stick(input logic [10:0] raw);
        int v;
        int db;
        int lim;
        v = int'(raw) - 1024;
        db = int'(band);
        lim = int'(clamp_lim);
        if (v <= db && v >= -db)
            v = 0;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[10:0];
    endfunction

    task automatic reset_model();
        band = DEAD_BAND_RESET;
        clamp_lim = CHANNEL_LIMIT_RESET;
        want_len = FRAME_LENGTH_RESET;
        burst_len = 0;
        for (int i = 0; i < STORED_BYTES; i++)
            held_bytes[i] = 8'h00;
        sw_one = 2'b00;
        sw_two = 2'b00;
        sw_one_prev = 2'b00;
        sw_two_prev = 2'b00;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEAD_BAND:     band = data[9:0];
            CFG_CHANNEL_LIMIT: clamp_lim = data[10:0];
            CFG_FRAME_LENGTH:  want_len = data[7:0];
            default: ;
        endcase
    endtask

    task automatic decode_word(input logic [7:0] b, input logic idle);
        logic [47:0] head;
        logic [1:0]  s1;
        logic [1:0]  s2;
        rc_report_t  r;
        if (!idle) begin
            if (burst_len < BUFFER_DEPTH) begin
                if (burst_len < STORED_BYTES)
                    held_bytes[burst_len] = b;
                burst_len++;
            end
        end else if (burst_len != int'(want_len)) begin
            burst_len = 0;
        end else begin
            burst_len = 0;
            head = {held_bytes[5], held_bytes[4], held_bytes[3],
                    held_bytes[2], held_bytes[1], held_bytes[0]};
            s1 = held_bytes[5][7:6];
            s2 = held_bytes[5][5:4];
            if (s1 != sw_one)
                sw_one_prev = sw_one;
            if (s2 != sw_two)
                sw_two_prev = sw_two;
            sw_one = s1;
            sw_two = s2;
            r.stick_one = shape_stick(head[10:0]);
            r.stick_two = shape_stick(head[21:11]);
            r.stick_three = shape_stick(head[32:22]);
            r.stick_four = shape_stick(head[43:33]);
            r.switches_now = {sw_one, sw_two};
            r.switches_before = {sw_one_prev, sw_two_prev};
            r.mouse_x = {held_bytes[7], held_bytes[6]};
            r.mouse_y = {held_bytes[9], held_bytes[8]};
            r.mouse_z = {held_bytes[11], held_bytes[10]};
            r.left_button = held_bytes[12];
            r.right_button = held_bytes[13];
            r.key_bits = {held_bytes[15], held_bytes[14]};
            pending_reports.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            miss_count++;
        end
    endtask

    task automatic compare_report();
        rc_report_t want;
        if (pending_reports.size() == 0) begin
            $error("result word arrived with no decoded frame pending");
            miss_count++;
        end else begin
            want = pending_reports.pop_front();
            check_field("stick_one", want.stick_one, stick_one);
            check_field("stick_two", want.stick_two, stick_two);
            check_field("stick_three", want.stick_three, stick_three);
            check_field("stick_four", want.stick_four, stick_four);
            check_field("switches_now", want.switches_now, switches_now);
            check_field("switches_before", want.switches_before, switches_before);
            check_field("mouse_x", want.mouse_x, mouse_x);
            check_field("mouse_y", want.mouse_y, mouse_y);
            check_field("mouse_z", want.mouse_z, mouse_z);
            check_field("left_button", want.left_button, left_button);
            check_field("right_button", want.right_button, right_button);
            check_field("key_bits", want.key_bits, key_bits);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reset_model();
            pending_reports.delete();
        end else begin
            if (out_valid && out_ready)
                compare_report();
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                decode_word(rx_byte, line_idle);
        end
        outstanding <= pending_reports.size();
        failures <= miss_count;
    end

endmodule

>>> test/testbench.sv
// Top of the frame decoder testbench: clock, reset, directed and random word stimulus,
// register writes between phases, and the final verdict.
// Depends on rcfd_pkg, rc_receiver_frame_decoder and rcfd_checker.

module testbench;
    import rcfd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RUN_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic [7:0]             rx_byte = 8'h00;
    logic                   line_idle = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   cfg_ready;
    logic                   out_valid;
    logic signed [10:0]     stick_one;
    logic signed [10:0]     stick_two;
    logic signed [10:0]     stick_three;
    logic signed [10:0]     stick_four;
    logic [3:0]             switches_now;
    logic [3:0]             switches_before;
    logic signed [15:0]     mouse_x;
    logic signed [15:0]     mouse_y;
    logic signed [15:0]     mouse_z;
    logic [7:0]             left_button;
    logic [7:0]             right_button;
    logic [15:0]            key_bits;
    int                     outstanding;
    int                     failures;

    int         words_sent = 0;
    int         burst_left = 0;
    int         cur_band = DEAD_BAND_RESET;
    int         cur_lim = CHANNEL_LIMIT_RESET;
    int         cur_len = FRAME_LENGTH_RESET;
    logic [7:0] frame_img [STORED_BYTES];

    rc_receiver_frame_decoder uut (.*);

    rcfd_checker checker_inst (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int span;
        int tick;
        tick = 0;
        forever begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge clk);
                tick++;
                case (mode)
                    READY_ALWAYS:  out_ready <= 1'b1;
                    READY_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
                    default:       out_ready <= (tick % 7) < 3;
                endcase
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic idle);
        int gap;
        in_valid <= 1'b1;
        rx_byte <= b;
        line_idle <= idle;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEAD_BAND:     cur_band = data & 32'h3FF;
            CFG_CHANNEL_LIMIT: cur_lim = data & 32'h7FF;
            CFG_FRAME_LENGTH:  cur_len = data & 32'hFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stick values cluster around the dead band and clamp edges as well as the rails.
    function automatic logic [10:0] pick_channel();
        int v;
        int sgn;
        sgn = ($urandom_range(0, 1) == 0) ? 1 : -1;
        case ($urandom_range(0, 5))
            0: v = int'($urandom_range(0, 2047));
            1: v = 1024 + sgn * (cur_band + int'($urandom_range(0, 1)));
            2: v = 1024 + sgn * (cur_lim - 1 + int'($urandom_range(0, 2)));
            3: v = ($urandom_range(0, 1) == 0) ? 2047 : 0;
            4: v = 1023 + int'($urandom_range(0, 2));
            default: v = int'($urandom_range(0, 2047));
        endcase
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return v[10:0];
    endfunction

    task automatic build_frame();
        logic [47:0] head;
        int fill;
        head = {2'($urandom), 2'($urandom), pick_channel(), pick_channel(),
                pick_channel(), pick_channel()};
        fill = $urandom_range(0, 7);
        for (int i = 0; i < STORED_BYTES; i++) begin
            if (i < 6)
                frame_img[i] = head[8*i +: 8];
            else if (fill == 0)
                frame_img[i] = (i % 2 == 0) ? 8'h00 : 8'h80;
            else if (fill == 1)
                frame_img[i] = (i % 2 == 0) ? 8'hFF : 8'h7F;
            else
                frame_img[i] = 8'($urandom);
        end
    endtask

    task automatic send_burst(input int n);
        for (int i = 0; i < n; i++)
            send_word((i < STORED_BYTES) ? frame_img[i] : 8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    task automatic run_phase(input int band, input int lim, input int len, input int budget);
        int start;
        int pick;
        int n;
        drain();
        set_reg(CFG_DEAD_BAND, band);
        set_reg(CFG_CHANNEL_LIMIT, lim);
        set_reg(CFG_FRAME_LENGTH, len);
        set_reg(CFG_SPARE, $urandom_range(0, 2047));
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            build_frame();
            if (pick < 70)
                n = (cur_len > BUFFER_DEPTH) ? $urandom_range(0, 20) : cur_len;
            else if (pick < 80)
                n = ($urandom_range(0, 1) == 0) ? cur_len + 1 : cur_len - 1;
            else if (pick < 85)
                n = -1;
            else if (pick < 97)
                n = $urandom_range(0, 24);
            else
                n = BUFFER_DEPTH + $urandom_range(0, 6);
            if (n < 0)
                send_word(8'($urandom), 1'b1);
            else
                send_burst(n);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero frame length decodes the cleared store straight after reset.
        set_reg(CFG_FRAME_LENGTH, 0);
        send_word(8'hA5, 1'b1);
        drain();
        set_reg(CFG_FRAME_LENGTH, FRAME_LENGTH_RESET);
        send_word(8'h5A, 1'b1);
        for (int i = 0; i < FRAME_LENGTH_RESET; i++)
            send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        drain();
        // A one-byte frame rewrites byte zero only and decodes the stale rest.
        set_reg(CFG_FRAME_LENGTH, 1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);

        run_phase(DEAD_BAND_RESET, CHANNEL_LIMIT_RESET, FRAME_LENGTH_RESET, 150);
        run_phase(0, 0, 18, 80);
        run_phase(1023, 1024, 16, 100);
        run_phase($urandom_range(0, 40), $urandom_range(600, 1024), $urandom_range(1, 15), 120);
        run_phase($urandom_range(0, 1023), $urandom_range(0, 1024), BUFFER_DEPTH, 300);
        run_phase(0, 1024, 255, 50);
        run_phase($urandom_range(0, 1023), $urandom_range(0, 1024), $urandom_range(16, 20), 150);
        run_phase(DEAD_BAND_RESET, CHANNEL_LIMIT_RESET, FRAME_LENGTH_RESET, 100);

        drain();
        if (failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rcfd_pkg.sv
hdl/rcfd_front.sv
hdl/rcfd_queue.sv
hdl/rcfd_back.sv
hdl/rc_receiver_frame_decoder.sv
test/rcfd_checker.sv
test/testbench.sv
